// File: src/sdc_pkg.sv
`default_nettype none

package sdc_pkg;

  // Field and register widths.
  localparam int SCALE_W  = 16;
  localparam int MIN_W    = 11;
  localparam int TVAL_W   = 28;
  localparam int DAY_W    = 32;
  localparam int TIME_W   = 27;
  localparam int WORK_W   = 29;
  localparam int BND_W    = 28;
  localparam int HOUR_W   = 5;
  localparam int IDX_W    = 6;
  localparam int CFG_IDX_W = 2;

  // Most hour events reported for one transaction.
  localparam int HOUR_EVENTS_MAX = 24;
  localparam int CNT_W = $clog2(HOUR_EVENTS_MAX + 1);

  localparam int HOURS_PER_DAY = 24;

  localparam logic [TIME_W-1:0]  DAY_MS          = TIME_W'(86400000);
  localparam logic [TIME_W-1:0]  SET_HOUR_MAX_MS = TIME_W'(86396400);
  localparam logic [BND_W-1:0]   HOUR_MS         = BND_W'(3600000);
  localparam logic [SCALE_W-1:0] MINUTE_MS       = SCALE_W'(60000);

  typedef enum logic [1:0] {
    OP_TICK,
    OP_SET_HOUR,
    OP_SET_DAY,
    OP_ADD_HOURS
  } op_t;

  localparam logic [1:0] EV_HOUR    = 2'd0;
  localparam logic [1:0] EV_DAY     = 2'd1;
  localparam logic [1:0] EV_NIGHT   = 2'd2;
  localparam logic [1:0] EV_DAYTIME = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAY_START   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_START = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_SCAN_HR,
    ST_WRAP,
    ST_SET_HOUR,
    ST_SET_DAY,
    ST_SCAN_LWH,
    ST_COMMIT,
    ST_NIGHT,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_MUL,
    DP_ADD_TICK,
    DP_ADD_HOURS,
    DP_SCAN,
    DP_WRAP,
    DP_SET_HOUR,
    DP_SET_DAY,
    DP_COMMIT,
    DP_NIGHT,
    DP_POP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   force_flip;
  } dp_cmd_t;

  typedef struct packed {
    logic scale_zero;
    logic scan_more;
    logic pending;
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: src/sdc_ctrl.sv
`default_nettype none

module sdc_ctrl import sdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] operation,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  op_t    op_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q <= op_t'(operation);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(operation))
            OP_TICK:      state_next = status.scale_zero ? ST_IDLE : ST_MUL;
            OP_SET_HOUR:  state_next = ST_SET_HOUR;
            OP_SET_DAY:   state_next = ST_SET_DAY;
            OP_ADD_HOURS: state_next = ST_ADD;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL:      state_next = ST_ADD;
      ST_ADD:      state_next = ST_SCAN_HR;
      ST_SCAN_HR:  state_next = status.scan_more ? ST_SCAN_HR : ST_WRAP;
      ST_WRAP:     state_next = ST_SCAN_LWH;
      ST_SET_HOUR: state_next = ST_SCAN_LWH;
      ST_SCAN_LWH: state_next = status.scan_more ? ST_SCAN_LWH : ST_COMMIT;
      ST_COMMIT:   state_next = ST_NIGHT;
      ST_SET_DAY:  state_next = ST_NIGHT;
      ST_NIGHT:    state_next = ST_EMIT;
      ST_EMIT: begin
        if (!status.pending || (out_ready && status.last)) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd.op         = DP_NONE;
    cmd.force_flip = (op_q != OP_TICK);
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = DP_LOAD;
        end
      end
      ST_MUL:      cmd.op = DP_MUL;
      ST_ADD:      cmd.op = (op_q == OP_TICK) ? DP_ADD_TICK : DP_ADD_HOURS;
      ST_SCAN_HR:  cmd.op = DP_SCAN;
      ST_WRAP:     cmd.op = DP_WRAP;
      ST_SET_HOUR: cmd.op = DP_SET_HOUR;
      ST_SET_DAY:  cmd.op = DP_SET_DAY;
      ST_SCAN_LWH: cmd.op = DP_SCAN;
      ST_COMMIT:   cmd.op = DP_COMMIT;
      ST_NIGHT:    cmd.op = DP_NIGHT;
      ST_EMIT: begin
        out_valid = status.pending;
        if (status.pending && out_ready) begin
          cmd.op = DP_POP;
        end
      end
      default:     cmd.op = DP_NONE;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output side open at once");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && status.last) |=> in_ready)
    else $error("block did not return to idle after final event");

endmodule

`default_nettype wire

// File: src/sdc_datapath.sv
`default_nettype none

module sdc_datapath import sdc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [SCALE_W-1:0]       cfg_data,
  input  logic [SCALE_W-1:0]       elapsed_real_ms,
  input  logic signed [TVAL_W-1:0] time_value_ms,
  input  logic signed [DAY_W-1:0]  day_value,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  output logic [1:0]               event_kind,
  output logic signed [DAY_W-1:0]  event_value,
  output logic [TIME_W-1:0]        time_of_day_ms,
  output logic signed [DAY_W-1:0]  day_number,
  output logic                     is_night,
  output logic                     last_event
);

  // Configuration and architectural state.
  logic [SCALE_W-1:0]      time_scale;
  logic [MIN_W-1:0]        day_start_minute;
  logic [MIN_W-1:0]        night_start_minute;
  logic [TIME_W-1:0]       time_of_day;
  logic signed [DAY_W-1:0] current_day;
  logic [HOUR_W-1:0]       last_whole_hour;
  logic                    night_flag;

  // Pending event bookkeeping.
  logic [CNT_W-1:0] hour_cnt;
  logic             day_ev;
  logic             dn_ev;

  // Working registers of one transaction.
  logic [SCALE_W-1:0]       elapsed_q;
  logic signed [TVAL_W-1:0] tval_q;
  logic signed [DAY_W-1:0]  dval_q;
  logic [DAY_W-1:0]         product;
  logic signed [WORK_W-1:0] work_t;
  logic [BND_W-1:0]         bnd;
  logic [IDX_W-1:0]         idx;
  logic [HOUR_W-1:0]        hour_val;
  logic [1:0]               dn_kind;
  logic [TIME_W-1:0]        day_start_ms;
  logic [TIME_W-1:0]        night_start_ms;

  logic signed [WORK_W-1:0] day_w;
  logic signed [TVAL_W-1:0] day_tv;
  logic signed [TVAL_W-1:0] set_max_tv;
  logic [TIME_W-1:0]        tick_sat;
  logic signed [TVAL_W-1:0] add_clamped;
  logic signed [WORK_W-1:0] delta;
  logic signed [WORK_W-1:0] add_sum;
  logic [TIME_W-1:0]        set_clamped;
  logic [IDX_W-1:0]         lwh_inc;
  logic [BND_W-1:0]         bnd_first;
  logic [IDX_W-1:0]         hours_crossed;
  logic [CNT_W-1:0]         hours_capped;
  logic [HOUR_W-1:0]        next_hour;
  logic                     scan_more;
  logic                     daytime;
  logic                     night_now;
  logic [CNT_W:0]           remaining;

  assign day_w      = $signed({2'b00, DAY_MS});
  assign day_tv     = $signed({1'b0, DAY_MS});
  assign set_max_tv = $signed({1'b0, SET_HOUR_MAX_MS});

  always_comb begin
    tick_sat = (product > DAY_W'(DAY_MS)) ? DAY_MS : product[TIME_W-1:0];

    if (tval_q > day_tv) begin
      add_clamped = day_tv;
    end else if (tval_q < -day_tv) begin
      add_clamped = -day_tv;
    end else begin
      add_clamped = tval_q;
    end

    if (cmd.op == DP_ADD_TICK) begin
      delta = $signed({2'b00, tick_sat});
    end else begin
      delta = $signed({add_clamped[TVAL_W-1], add_clamped});
    end
    add_sum = $signed({2'b00, time_of_day}) + delta;

    if (tval_q < 0) begin
      set_clamped = '0;
    end else if (tval_q > set_max_tv) begin
      set_clamped = SET_HOUR_MAX_MS;
    end else begin
      set_clamped = tval_q[TIME_W-1:0];
    end
  end

  assign lwh_inc   = IDX_W'(last_whole_hour) + IDX_W'(1);
  assign bnd_first = BND_W'(lwh_inc) * HOUR_MS;

  assign hours_crossed = idx - IDX_W'(last_whole_hour);
  assign hours_capped  = (hours_crossed > IDX_W'(HOUR_EVENTS_MAX)) ?
                         CNT_W'(HOUR_EVENTS_MAX) : hours_crossed[CNT_W-1:0];
  assign next_hour     = (last_whole_hour == HOUR_W'(HOURS_PER_DAY - 1)) ?
                         '0 : last_whole_hour + HOUR_W'(1);

  assign scan_more = (work_t >= $signed({1'b0, bnd}));

  // Day window test; when the start lies at or after the end the window wraps midnight.
  always_comb begin
    if (day_start_ms < night_start_ms) begin
      daytime = (time_of_day >= day_start_ms) && (time_of_day < night_start_ms);
    end else begin
      daytime = (time_of_day >= day_start_ms) || (time_of_day < night_start_ms);
    end
    night_now = !daytime;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_scale         <= SCALE_W'(600);
      day_start_minute   <= MIN_W'(300);
      night_start_minute <= MIN_W'(1320);
      time_of_day        <= TIME_W'(28800000);
      current_day        <= DAY_W'(1);
      last_whole_hour    <= HOUR_W'(8);
      night_flag         <= 1'b0;
      hour_cnt           <= '0;
      day_ev             <= 1'b0;
      dn_ev              <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_TIME_SCALE:  time_scale         <= cfg_data;
          CFG_DAY_START:   day_start_minute   <= cfg_data[MIN_W-1:0];
          CFG_NIGHT_START: night_start_minute <= cfg_data[MIN_W-1:0];
          default: ;
        endcase
      end
      unique case (cmd.op)
        DP_LOAD: begin
          hour_cnt <= '0;
          day_ev   <= 1'b0;
          dn_ev    <= 1'b0;
        end
        DP_WRAP: begin
          hour_cnt <= hours_capped;
          if (work_t >= day_w) begin
            current_day <= current_day + DAY_W'(1);
            day_ev      <= 1'b1;
          end else if (work_t < 0) begin
            current_day <= current_day - DAY_W'(1);
            day_ev      <= 1'b1;
          end
        end
        DP_SET_DAY: begin
          current_day <= (dval_q < $signed(DAY_W'(1))) ? DAY_W'(1) : dval_q;
          day_ev      <= 1'b1;
        end
        DP_COMMIT: begin
          time_of_day     <= work_t[TIME_W-1:0];
          last_whole_hour <= idx[HOUR_W-1:0];
        end
        DP_NIGHT: begin
          night_flag <= night_now;
          dn_ev      <= (night_now != night_flag) || cmd.force_flip;
        end
        DP_POP: begin
          if (hour_cnt != '0) begin
            hour_cnt <= hour_cnt - CNT_W'(1);
          end else if (day_ev) begin
            day_ev <= 1'b0;
          end else begin
            dn_ev <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    day_start_ms   <= TIME_W'(day_start_minute) * TIME_W'(MINUTE_MS);
    night_start_ms <= TIME_W'(night_start_minute) * TIME_W'(MINUTE_MS);
    unique case (cmd.op)
      DP_LOAD: begin
        elapsed_q <= elapsed_real_ms;
        tval_q    <= time_value_ms;
        dval_q    <= day_value;
      end
      DP_MUL: begin
        product <= DAY_W'(elapsed_q) * DAY_W'(time_scale);
      end
      DP_ADD_TICK, DP_ADD_HOURS: begin
        work_t <= add_sum;
        idx    <= IDX_W'(last_whole_hour);
        bnd    <= bnd_first;
      end
      DP_SCAN: begin
        if (scan_more) begin
          idx <= idx + IDX_W'(1);
          bnd <= bnd + HOUR_MS;
        end
      end
      DP_WRAP: begin
        hour_val <= next_hour;
        if (work_t >= day_w) begin
          work_t <= work_t - day_w;
        end else if (work_t < 0) begin
          work_t <= work_t + day_w;
        end
        idx <= '0;
        bnd <= HOUR_MS;
      end
      DP_SET_HOUR: begin
        work_t <= $signed({2'b00, set_clamped});
        idx    <= '0;
        bnd    <= HOUR_MS;
      end
      DP_NIGHT: begin
        dn_kind <= night_now ? EV_NIGHT : EV_DAYTIME;
      end
      DP_POP: begin
        if (hour_cnt != '0) begin
          hour_val <= (hour_val == HOUR_W'(HOURS_PER_DAY - 1)) ?
                      '0 : hour_val + HOUR_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign remaining = (CNT_W+1)'(hour_cnt) + (CNT_W+1)'(day_ev) + (CNT_W+1)'(dn_ev);

  assign status.scale_zero = (time_scale == '0);
  assign status.scan_more  = scan_more;
  assign status.pending    = (remaining != '0);
  assign status.last       = (remaining == (CNT_W+1)'(1));

  always_comb begin
    if (hour_cnt != '0) begin
      event_kind  = EV_HOUR;
      event_value = $signed(DAY_W'(hour_val));
    end else if (day_ev) begin
      event_kind  = EV_DAY;
      event_value = current_day;
    end else begin
      event_kind  = dn_kind;
      event_value = '0;
    end
  end

  assign time_of_day_ms = time_of_day;
  assign day_number     = current_day;
  assign is_night       = night_flag;
  assign last_event     = status.last;

  a_time_in_day: assert property (@(posedge clk) disable iff (rst)
    time_of_day < DAY_MS)
    else $error("time of day out of range");

  a_hour_matches_time: assert property (@(posedge clk) disable iff (rst)
    (BND_W'(time_of_day) >= BND_W'(last_whole_hour) * HOUR_MS) &&
    (BND_W'(time_of_day) < BND_W'(IDX_W'(last_whole_hour) + IDX_W'(1)) * HOUR_MS))
    else $error("whole hour does not match time of day");

  a_hour_cap: assert property (@(posedge clk) disable iff (rst)
    hour_cnt <= CNT_W'(HOUR_EVENTS_MAX))
    else $error("too many hour events queued");

endmodule

`default_nettype wire

// File: src/scaled_day_clock_with_events_core.sv
`default_nettype none

// Scaled time-of-day clock. Game time is kept as milliseconds into the day plus a 32-bit day
// counter. Each input transaction is one of four operations: a tick advances the time by the
// elapsed real milliseconds times time_scale (zero pauses the clock), set hour loads a clamped
// time, set day loads a day number of at least one, and add hours moves the time by a signed
// amount. Every advance saturates at one day. A transaction produces zero to 26 output
// transactions: one per whole hour crossed (at most 24), then a day event on a midnight
// rollover, then a night or day event when the day/night state changes; set hour, set day and
// add hours always end with a night or day event. Every event carries the time, day and night
// flag as they stand after the whole operation, and last_event marks the final one. The block
// handles one transaction at a time. A tick runs multiply, add, an hour scan, midnight wrap, a
// second hour scan, commit and the night update before its first event; an add skips the
// multiply, set hour loads the time and runs only the second scan, commit and night update,
// and set day goes straight to the night update. Each event is then held until out_ready
// takes it, and an operation with no events passes through the emit state before the block
// is ready again. The two passes of a shared hour-boundary compare advance one hour per
// cycle, one counting the hours crossed and one finding the whole hour of the new time. A tick
// with time_scale zero is accepted and produces nothing. Configuration writes take effect at
// once and should be issued only while the block is idle.
module scaled_day_clock_with_events_core import sdc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration write port.
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [SCALE_W-1:0]       cfg_data,
  // Input channel.
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               operation,
  input  logic [SCALE_W-1:0]       elapsed_real_ms,
  input  logic signed [TVAL_W-1:0] time_value_ms,
  input  logic signed [DAY_W-1:0]  day_value,
  // Output channel.
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               event_kind,
  output logic signed [DAY_W-1:0]  event_value,
  output logic [TIME_W-1:0]        time_of_day_ms,
  output logic signed [DAY_W-1:0]  day_number,
  output logic                     is_night,
  output logic                     last_event
);

  // The controller sequences each operation and the event drain; the datapath holds all
  // clock state and does the arithmetic on command.
  dp_cmd_t    cmd;
  dp_status_t status;

  sdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Output fields come straight from datapath registers and stay stable while an event
  // waits for out_ready.
  sdc_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .elapsed_real_ms (elapsed_real_ms),
    .time_value_ms   (time_value_ms),
    .day_value       (day_value),
    .cmd             (cmd),
    .status          (status),
    .event_kind      (event_kind),
    .event_value     (event_value),
    .time_of_day_ms  (time_of_day_ms),
    .day_number      (day_number),
    .is_night        (is_night),
    .last_event      (last_event)
  );

endmodule

`default_nettype wire
